// ----- design/twrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrm_pkg
// Shared types and codes for the tile window residency manager.
// ----------------------------------------------------------------------------
package twrm_pkg;

  typedef enum logic [1:0] {
    OP_MOVE      = 2'd0,
    OP_LOAD_DONE = 2'd1,
    OP_READ      = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_UNSEEN  = 2'd0,
    PH_SEEN    = 2'd1,
    PH_LOADING = 2'd2,
    PH_READY   = 2'd3
  } phase_e;

  localparam logic CFG_NEAR_RADIUS = 1'b0;
  localparam logic CFG_MID_RADIUS  = 1'b1;

  localparam logic [2:0] NEAR_RESET = 3'd1;
  localparam logic [2:0] MID_RESET  = 3'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CULL,
    ST_TILE,
    ST_PROBE,
    ST_DETAIL,
    ST_SLOT
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] player_x;
    logic signed [23:0] player_z;
    logic [6:0]         slot_index;
  } twrm_in_t;

  typedef struct packed {
    logic signed [11:0] centre_x;
    logic signed [11:0] centre_z;
    logic [6:0]         new_loads;
    logic               out_of_slots;
    logic               accepted;
    logic signed [11:0] tile_x;
    logic signed [11:0] tile_z;
    logic [1:0]         detail_level;
    logic [1:0]         slot_status;
  } twrm_out_t;

  typedef struct packed {
    logic [11:0] tx;
    logic [11:0] tz;
    logic [1:0]  detail;
    phase_e      phase;
  } slot_t;

endpackage

// ----- design/tile_window_residency_manager_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_window_residency_manager_top
// Slot table for a GRID x GRID tile window held in one synchronous memory.
// Move: cull sweep over the slots, assignment walk (a window tile not yet
// held takes the next free slot), detail sweep over the slots.
// Load finished and read access one slot.
// After reset the memory is filled with busy_o high.
// Results show for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tile_window_residency_manager_top import twrm_pkg::*; #(
  parameter int GRID       = 9,
  parameter int SLOTS      = 81,
  parameter int TILE_SHIFT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  twrm_in_t  item_i,
  output logic      done_o,
  output twrm_out_t result_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [2:0] cfg_data_i
);

  localparam int HALF = GRID / 2;
  localparam int NT   = GRID * GRID;
  localparam int AW   = $clog2(SLOTS);
  localparam int SW   = $clog2(SLOTS + 1);
  localparam int GW   = $clog2(GRID);
  localparam int NW   = $clog2(NT);
  localparam logic signed [24:0] C_LO = 25'(-2048 + HALF);
  localparam logic signed [24:0] C_HI = 25'(2047 - (GRID - 1 - HALF));
  localparam logic signed [24:0] RND  = 25'(1 << (TILE_SHIFT + 7));

  state_e      state_q, state_d;
  logic [SW-1:0] sc_q, sc_d, sp_q, sp_d;
  logic [GW-1:0] ti_q, ti_d, tj_q, tj_d;
  logic [NT-1:0] occ_q, occ_d;
  logic [11:0] cx_q, cx_d, cz_q, cz_d;
  logic [2:0]  near_q, mid_q;
  op_e         op_q, op_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [6:0]  loads_q, loads_d;
  logic        short_q, short_d;
  logic        done_q, done_d;
  twrm_out_t   res_q, res_d;

  slot_t       mem [SLOTS];
  slot_t       rd_q, wd;
  logic        we;
  logic [AW-1:0] wa, ra;

  logic signed [24:0] sx, sz, fx, fz;
  logic signed [12:0] ox, oz;
  logic        in_win;
  logic [NW-1:0] occ_idx, tile_idx;
  logic        tile_last;
  logic [GW-1:0] ti_nx, tj_nx;
  logic [11:0] win_tx, win_tz;
  logic [AW-1:0] prev_a;

  function automatic logic [12:0] absdiff(input logic [11:0] a, input logic [11:0] b);
    logic signed [12:0] d;
    d = $signed({a[11], a}) - $signed({b[11], b});
    return d[12] ? 13'(-d) : 13'(d);
  endfunction

  function automatic logic [1:0] ring(input logic [11:0] tx, input logic [11:0] tz,
                                      input logic [11:0] cx, input logic [11:0] cz,
                                      input logic [2:0] nr, input logic [2:0] mr);
    logic [12:0] dx, dz, d;
    dx = absdiff(tx, cx);
    dz = absdiff(tz, cz);
    d  = (dx > dz) ? dx : dz;
    if (d <= {10'd0, nr}) return 2'd3;
    if (d <= {10'd0, mr}) return 2'd2;
    return 2'd1;
  endfunction

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NEAR_RESET;
      mid_q  <= MID_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NEAR_RADIUS) near_q <= cfg_data_i;
      if (cfg_idx_i == CFG_MID_RADIUS)  mid_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sc_q    <= '0;
      sp_q    <= '0;
      ti_q    <= '0;
      tj_q    <= '0;
      occ_q   <= '0;
      cx_q    <= '0;
      cz_q    <= '0;
      op_q    <= OP_NOP;
      idx_q   <= '0;
      loads_q <= '0;
      short_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sc_q    <= sc_d;
      sp_q    <= sp_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      occ_q   <= occ_d;
      cx_q    <= cx_d;
      cz_q    <= cz_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      loads_q <= loads_d;
      short_q <= short_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // centre tile from the incoming position
  always_comb begin
    sx = {item_i.player_x[23], item_i.player_x} + RND;
    sz = {item_i.player_z[23], item_i.player_z} + RND;
    fx = sx >>> (TILE_SHIFT + 8);
    fz = sz >>> (TILE_SHIFT + 8);
    if (fx < C_LO) fx = C_LO;
    else if (fx > C_HI) fx = C_HI;
    if (fz < C_LO) fz = C_LO;
    else if (fz > C_HI) fz = C_HI;
  end

  // window test of the slot just read
  always_comb begin
    ox = $signed({rd_q.tx[11], rd_q.tx}) - $signed({cx_q[11], cx_q}) + 13'(HALF);
    oz = $signed({rd_q.tz[11], rd_q.tz}) - $signed({cz_q[11], cz_q}) + 13'(HALF);
    in_win = !ox[12] && !oz[12] && (ox <= 13'(GRID - 1)) && (oz <= 13'(GRID - 1));
    occ_idx = NW'(ox[GW-1:0] * GRID + oz[GW-1:0]);
    tile_idx = NW'(ti_q * GRID + tj_q);
    tile_last = (ti_q == GW'(GRID - 1)) && (tj_q == GW'(GRID - 1));
    if (tj_q == GW'(GRID - 1)) begin
      tj_nx = '0;
      ti_nx = ti_q + 1'b1;
    end else begin
      tj_nx = tj_q + 1'b1;
      ti_nx = ti_q;
    end
    win_tx = cx_q - 12'(HALF) + 12'(ti_q);
    win_tz = cz_q - 12'(HALF) + 12'(tj_q);
    prev_a = AW'(sc_q - 1'b1);
  end

  always_comb begin
    state_d = state_q;
    sc_d    = sc_q;
    sp_d    = sp_q;
    ti_d    = ti_q;
    tj_d    = tj_q;
    occ_d   = occ_q;
    cx_d    = cx_q;
    cz_d    = cz_q;
    op_d    = op_q;
    idx_d   = idx_q;
    loads_d = loads_q;
    short_d = short_q;
    done_d  = 1'b0;
    res_d   = '0;
    we      = 1'b0;
    wa      = prev_a;
    wd      = rd_q;
    ra      = sc_q[AW-1:0];

    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        wa = sc_q[AW-1:0];
        if (sc_q < SW'(NT)) begin
          wd.tx     = 12'(ti_q) - 12'(HALF);
          wd.tz     = 12'(tj_q) - 12'(HALF);
          wd.phase  = PH_SEEN;
          wd.detail = ring(wd.tx, wd.tz, '0, '0, NEAR_RESET, MID_RESET);
        end else begin
          wd.tx     = '0;
          wd.tz     = '0;
          wd.phase  = PH_UNSEEN;
          wd.detail = 2'd1;
        end
        ti_d = ti_nx;
        tj_d = tj_nx;
        if (sc_q == SW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
          sc_d    = '0;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          op_d  = op_e'(item_i.op);
          idx_d = AW'(item_i.slot_index);
          ra    = AW'(item_i.slot_index);
          unique case (op_e'(item_i.op))
            OP_MOVE: begin
              cx_d    = fx[11:0];
              cz_d    = fz[11:0];
              occ_d   = '0;
              sc_d    = '0;
              loads_d = '0;
              short_d = 1'b0;
              state_d = ST_CULL;
            end
            OP_LOAD_DONE, OP_READ: begin
              if (32'(item_i.slot_index) < SLOTS) begin
                state_d = ST_SLOT;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      ST_CULL: begin
        if (sc_q != '0) begin
          if (!in_win) begin
            we       = 1'b1;
            wd.phase = PH_UNSEEN;
          end else if (rd_q.phase != PH_UNSEEN) begin
            occ_d[occ_idx] = 1'b1;
          end
        end
        if (sc_q == SW'(SLOTS)) begin
          state_d = ST_TILE;
          sp_d    = '0;
          ti_d    = '0;
          tj_d    = '0;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end

      ST_TILE: begin
        ra = sp_q[AW-1:0];
        if (occ_q[tile_idx] || sp_q == SW'(SLOTS)) begin
          if (!occ_q[tile_idx]) short_d = 1'b1;
          ti_d = ti_nx;
          tj_d = tj_nx;
          if (tile_last) begin
            state_d = ST_DETAIL;
            sc_d    = '0;
          end
        end else begin
          state_d = ST_PROBE;
        end
      end

      ST_PROBE: begin
        sp_d    = sp_q + 1'b1;
        state_d = ST_TILE;
        if (rd_q.phase == PH_UNSEEN) begin
          we       = 1'b1;
          wa       = sp_q[AW-1:0];
          wd.tx    = win_tx;
          wd.tz    = win_tz;
          wd.phase = PH_LOADING;
          loads_d  = loads_q + 1'b1;
          ti_d     = ti_nx;
          tj_d     = tj_nx;
          if (tile_last) begin
            state_d = ST_DETAIL;
            sc_d    = '0;
          end
        end
      end

      ST_DETAIL: begin
        if (sc_q != '0) begin
          we        = 1'b1;
          wd.detail = ring(rd_q.tx, rd_q.tz, cx_q, cz_q, near_q, mid_q);
          if (rd_q.phase == PH_READY) wd.phase = PH_SEEN;
        end
        if (sc_q == SW'(SLOTS)) begin
          state_d            = ST_IDLE;
          done_d             = 1'b1;
          res_d.centre_x     = cx_q;
          res_d.centre_z     = cz_q;
          res_d.new_loads    = loads_q;
          res_d.out_of_slots = short_q;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end

      ST_SLOT: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        wa      = idx_q;
        if (op_q == OP_LOAD_DONE) begin
          if (rd_q.phase == PH_LOADING) begin
            we             = 1'b1;
            wd.phase       = PH_READY;
            res_d.accepted = 1'b1;
          end
        end else begin
          res_d.tile_x       = rd_q.tx;
          res_d.tile_z       = rd_q.tz;
          res_d.detail_level = rd_q.detail;
          res_d.slot_status  = rd_q.phase;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
